@@ rtl/core/array_binary_tree_free_list_assert.svh @@
// assertion macros for the array binary tree free list block
// no dependencies; included by modules that carry concurrent checks
`ifndef ARRAY_BINARY_TREE_FREE_LIST_ASSERT_SVH
`define ARRAY_BINARY_TREE_FREE_LIST_ASSERT_SVH

`ifndef SYNTH

// property must hold at every clock edge outside reset
`define ABT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define ABT_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ABT_ASSERT(lbl, clk, rst_n, prop, msg)
`define ABT_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

@@ rtl/core/abtfl_pkg.sv @@
// shared types and constants of the array binary tree free list block
// no dependencies; used by controller, datapath and top level
package abtfl_pkg;

  // node store geometry
  localparam int NODES  = 128;
  localparam int IDX_W  = $clog2(NODES);
  localparam int LINK_W = 8;
  localparam int DATA_W = 32;
  localparam int REQ_W  = 3;

  // stream word widths
  localparam int IN_W  = 40;
  localparam int OUT_W = 80;

  localparam logic [LINK_W-1:0] LINK_NONE = '1;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_MAKE  = 3'd0,
    REQ_SETL  = 3'd1,
    REQ_SETR  = 3'd2,
    REQ_FREE  = 3'd3,
    REQ_QUERY = 3'd4
  } req_e;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_LINK,
    ST_CHILD,
    ST_QPAR,
    ST_QSIB,
    ST_FIN
  } state_e;

  // read address source
  typedef enum logic [1:0] {
    RD_POS,
    RD_FREE,
    RD_PAR
  } rd_sel_e;

  // controller to datapath
  typedef struct packed {
    logic    load_req;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    hold_en;
    logic    sweep_wr;
    logic    link_wr;
    logic    child_wr;
    logic    free_wr;
    logic    res_load;
    logic    nostore;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [REQ_W-1:0] req_in;
    logic [REQ_W-1:0] req_q;
    logic             free_ok;
    logic             sweep_last;
    logic             out_free;
  } sts_t;

endpackage

@@ rtl/core/abtfl_dpath.sv @@
// datapath: node stores, free head, root, sweep counter and result register
// depends on abtfl_pkg and the assertion macro header
`include "array_binary_tree_free_list_assert.svh"

module abtfl_dpath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  abtfl_pkg::cmd_t             cmd_i,
  output abtfl_pkg::sts_t             sts_o,
  input  logic [abtfl_pkg::IN_W-1:0]  s_tdata_i,
  input  logic [abtfl_pkg::REQ_W-1:0] s_tuser_i,
  output logic                        m_tvalid_o,
  input  logic                        m_tready_i,
  output logic [abtfl_pkg::OUT_W-1:0] m_tdata_o,
  output logic                        m_tuser_o
);
  import abtfl_pkg::*;

  // node stores
  logic [DATA_W-1:0] val_mem   [NODES];
  logic [LINK_W-1:0] left_mem  [NODES];
  logic [LINK_W-1:0] right_mem [NODES];
  logic [LINK_W-1:0] par_mem   [NODES];

  logic [DATA_W-1:0] val_rd_q;
  logic [LINK_W-1:0] left_rd_q, right_rd_q, par_rd_q;

  // request word
  logic [REQ_W-1:0]  req_q;
  logic [IDX_W-1:0]  pos_q;
  logic [DATA_W-1:0] data_q;

  // control state
  logic [LINK_W-1:0] free_head_q, free_head_d;
  logic [IDX_W-1:0]  root_q, root_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              out_valid_q, out_valid_d;

  // held query fields
  logic [DATA_W-1:0] hold_val_q;
  logic [LINK_W-1:0] hold_left_q, hold_right_q, hold_par_q;

  // result register
  logic              res_status_q;
  logic [LINK_W-1:0] res_alloc_q, res_left_q, res_right_q, res_par_q, res_sib_q;
  logic [DATA_W-1:0] res_val_q;
  logic [IDX_W-1:0]  res_root_q;

  logic [IDX_W-1:0]  pos_in;
  logic [DATA_W-1:0] data_in;
  logic [IDX_W-1:0]  rd_addr;
  logic              sweep_last;
  logic              sweep_first;
  logic [IDX_W-1:0]  child;

  logic              left_we, right_we, par_we, val_we;
  logic [IDX_W-1:0]  left_wa, right_wa, par_wa, val_wa;
  logic [LINK_W-1:0] left_wd, right_wd, par_wd;
  logic [DATA_W-1:0] val_wd;

  logic              res_status_d;
  logic [LINK_W-1:0] res_alloc_d, res_left_d, res_right_d, res_par_d, res_sib_d;
  logic [DATA_W-1:0] res_val_d;
  logic [IDX_W-1:0]  res_root_d;

  // input word fields
  assign pos_in  = s_tdata_i[IDX_W-1:0];
  assign data_in = s_tdata_i[IDX_W+DATA_W-1:IDX_W];

  assign sweep_last  = (idx_q == IDX_W'(NODES - 1));
  assign sweep_first = (idx_q == '0);
  assign child       = free_head_q[IDX_W-1:0];

  // status to controller
  assign sts_o.req_in     = s_tuser_i;
  assign sts_o.req_q      = req_q;
  assign sts_o.free_ok    = !free_head_q[LINK_W-1];
  assign sts_o.sweep_last = sweep_last;
  assign sts_o.out_free   = !out_valid_q || m_tready_i;

  // read address select
  always_comb begin
    case (cmd_i.rd_sel)
      RD_FREE: rd_addr = child;
      RD_PAR:  rd_addr = par_rd_q[IDX_W-1:0];
      default: rd_addr = (cmd_i.load_req) ? pos_in : pos_q;
    endcase
  end

  // left store write port
  always_comb begin
    left_we = 1'b0;
    left_wa = pos_q;
    left_wd = LINK_NONE;
    if (cmd_i.sweep_wr) begin
      left_we = 1'b1;
      left_wa = idx_q;
      left_wd = (sweep_first || sweep_last) ? LINK_NONE : ({1'b0, idx_q} + LINK_W'(1));
    end else if (cmd_i.link_wr && (req_q == REQ_SETL)) begin
      left_we = 1'b1;
      left_wa = pos_q;
      left_wd = {1'b0, child};
    end else if (cmd_i.child_wr) begin
      left_we = 1'b1;
      left_wa = child;
      left_wd = LINK_NONE;
    end else if (cmd_i.free_wr) begin
      left_we = 1'b1;
      left_wa = pos_q;
      left_wd = free_head_q;
    end
  end

  // right store write port
  always_comb begin
    right_we = 1'b0;
    right_wa = pos_q;
    right_wd = LINK_NONE;
    if (cmd_i.sweep_wr && sweep_first) begin
      right_we = 1'b1;
      right_wa = '0;
    end else if (cmd_i.link_wr && (req_q == REQ_SETR)) begin
      right_we = 1'b1;
      right_wa = pos_q;
      right_wd = {1'b0, child};
    end else if (cmd_i.child_wr) begin
      right_we = 1'b1;
      right_wa = child;
    end
  end

  // parent and value store write ports
  always_comb begin
    par_we = 1'b0;
    par_wa = child;
    par_wd = {1'b0, pos_q};
    val_we = 1'b0;
    val_wa = child;
    val_wd = data_q;
    if (cmd_i.sweep_wr && sweep_first) begin
      par_we = 1'b1;
      par_wa = '0;
      par_wd = LINK_NONE;
      val_we = 1'b1;
      val_wa = '0;
    end else if (cmd_i.child_wr) begin
      par_we = 1'b1;
      val_we = 1'b1;
    end
  end

  // memories with registered reads
  always_ff @(posedge clk_i) begin
    if (left_we) left_mem[left_wa] <= left_wd;
    if (cmd_i.rd_en) left_rd_q <= left_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (right_we) right_mem[right_wa] <= right_wd;
    if (cmd_i.rd_en) right_rd_q <= right_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (par_we) par_mem[par_wa] <= par_wd;
    if (cmd_i.rd_en) par_rd_q <= par_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (val_we) val_mem[val_wa] <= val_wd;
    if (cmd_i.rd_en) val_rd_q <= val_mem[rd_addr];
  end

  // free head, root, sweep counter and output valid
  always_comb begin
    free_head_d = free_head_q;
    root_d      = root_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !m_tready_i;
    if (cmd_i.sweep_wr) begin
      idx_d = sweep_last ? '0 : idx_q + IDX_W'(1);
      if (sweep_last) begin
        // node 0 taken as root, so entry 1 heads the list
        free_head_d = LINK_W'(1);
        root_d      = '0;
      end
    end
    if (cmd_i.child_wr) free_head_d = left_rd_q;
    if (cmd_i.free_wr)  free_head_d = {1'b0, pos_q};
    if (cmd_i.res_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q <= '0;
      root_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      free_head_q <= free_head_d;
      root_q      <= root_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result fields
  always_comb begin
    res_status_d = cmd_i.nostore;
    res_alloc_d  = LINK_NONE;
    res_val_d    = '0;
    res_left_d   = LINK_NONE;
    res_right_d  = LINK_NONE;
    res_par_d    = LINK_NONE;
    res_sib_d    = LINK_NONE;
    res_root_d   = (req_q == REQ_MAKE) ? '0 : root_q;
    case (req_q)
      REQ_MAKE: res_alloc_d = '0;
      REQ_SETL, REQ_SETR: begin
        if (!cmd_i.nostore) res_alloc_d = {1'b0, child};
      end
      REQ_QUERY: begin
        res_val_d   = hold_val_q;
        res_left_d  = hold_left_q;
        res_right_d = hold_right_q;
        res_par_d   = hold_par_q;
        // parent links now in the read registers
        if (!hold_par_q[LINK_W-1]) begin
          res_sib_d = (left_rd_q == {1'b0, pos_q}) ? right_rd_q : left_rd_q;
        end
      end
      default: res_alloc_d = LINK_NONE;
    endcase
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q  <= s_tuser_i;
      pos_q  <= pos_in;
      data_q <= data_in;
    end
    if (cmd_i.hold_en) begin
      hold_val_q   <= val_rd_q;
      hold_left_q  <= left_rd_q;
      hold_right_q <= right_rd_q;
      hold_par_q   <= par_rd_q;
    end
    if (cmd_i.res_load) begin
      res_status_q <= res_status_d;
      res_alloc_q  <= res_alloc_d;
      res_val_q    <= res_val_d;
      res_left_q   <= res_left_d;
      res_right_q  <= res_right_d;
      res_par_q    <= res_par_d;
      res_sib_q    <= res_sib_d;
      res_root_q   <= res_root_d;
    end
  end

  // output word
  assign m_tvalid_o = out_valid_q;
  assign m_tuser_o  = res_status_q;
  assign m_tdata_o  = {1'b0, res_root_q, res_sib_q, res_par_q, res_right_q, res_left_q,
                       res_val_q, res_alloc_q};

  // checks
  `ABT_ASSERT(a_child_in_range, clk_i, rst_ni, cmd_i.child_wr |-> sts_o.free_ok, "child write with empty list")
  `ABT_ASSERT(a_make_root, clk_i, rst_ni, (cmd_i.res_load && (req_q == REQ_MAKE)) |=> ((root_q == '0) && (free_head_q == LINK_W'(1))), "make_tree left bad root or free head")
  `ABT_ASSERT(a_sweep_wrap, clk_i, rst_ni, (cmd_i.sweep_wr && sweep_last) |=> (idx_q == '0), "sweep counter did not wrap")

endmodule

@@ rtl/core/abtfl_ctrl.sv @@
// controller state machine sequencing store reads, writes and result loads
// depends on abtfl_pkg and the assertion macro header
`include "array_binary_tree_free_list_assert.svh"

module abtfl_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_tvalid_i,
  output logic            s_tready_o,
  input  abtfl_pkg::sts_t sts_i,
  output abtfl_pkg::cmd_t cmd_o
);
  import abtfl_pkg::*;

  state_e state_q, state_d;
  logic   accept;
  logic [3:0] wr_vec;

  assign accept = s_tvalid_i && s_tready_o;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) begin
          case (sts_i.req_in)
            REQ_MAKE:           state_d = ST_SWEEP;
            REQ_SETL, REQ_SETR: state_d = ST_LINK;
            REQ_QUERY:          state_d = ST_QPAR;
            default:            state_d = ST_FIN;
          endcase
        end
      end
      ST_SWEEP: if (sts_i.sweep_last && sts_i.out_free) state_d = ST_IDLE;
      ST_LINK: begin
        if (sts_i.free_ok) state_d = ST_CHILD;
        else if (sts_i.out_free) state_d = ST_IDLE;
      end
      ST_CHILD: if (sts_i.out_free) state_d = ST_IDLE;
      ST_QPAR:  state_d = ST_QSIB;
      ST_QSIB:  if (sts_i.out_free) state_d = ST_IDLE;
      ST_FIN:   if (sts_i.out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_tready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.rd_sel = RD_POS;
    case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load_req = 1'b1;
          cmd_o.rd_en    = 1'b1;
          cmd_o.rd_sel   = (sts_i.req_in inside {REQ_SETL, REQ_SETR}) ? RD_FREE : RD_POS;
        end
      end
      ST_SWEEP: begin
        cmd_o.sweep_wr = !sts_i.sweep_last || sts_i.out_free;
        cmd_o.res_load = sts_i.sweep_last && sts_i.out_free;
      end
      ST_LINK: begin
        if (sts_i.free_ok) begin
          cmd_o.link_wr = 1'b1;
        end else if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          cmd_o.nostore  = 1'b1;
        end
      end
      ST_CHILD: begin
        cmd_o.child_wr = sts_i.out_free;
        cmd_o.res_load = sts_i.out_free;
      end
      ST_QPAR: begin
        cmd_o.hold_en = 1'b1;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = RD_PAR;
      end
      ST_QSIB: cmd_o.res_load = sts_i.out_free;
      ST_FIN: begin
        cmd_o.res_load = sts_i.out_free;
        cmd_o.free_wr  = sts_i.out_free && (sts_i.req_q == REQ_FREE);
      end
      default: cmd_o = '0;
    endcase
  end

  // checks
  assign wr_vec = {cmd_o.sweep_wr, cmd_o.link_wr, cmd_o.child_wr, cmd_o.free_wr};

  `ABT_ASSERT(a_res_slot, clk_i, rst_ni, cmd_o.res_load |-> sts_i.out_free, "result loaded into full slot")
  `ABT_ASSERT(a_one_writer, clk_i, rst_ni, $onehot0(wr_vec), "more than one store write source")
  `ABT_ASSERT(a_link_then_child, clk_i, rst_ni, (state_q == ST_LINK && cmd_o.link_wr) |=> (state_q == ST_CHILD), "link write not followed by child write")
  `ABT_ASSERT_NEVER(a_accept_busy, clk_i, rst_ni, accept && (state_q != ST_IDLE), "word accepted while busy")

endmodule

@@ rtl/core/array_binary_tree_free_list.sv @@
// top level of the array binary tree free list block
// depends on abtfl_pkg, abtfl_ctrl and abtfl_dpath
//
// channel  dir  tdata fields (lsb up)                        tuser
// s_axis   in   position[6:0], node_data[38:7], pad[39]      req_type[2:0]
// m_axis   out  alloc_index[7:0], node_value[39:8],          status[0]
//               left_link[47:40], right_link[55:48],
//               parent_link[63:56], sibling_link[71:64],
//               root_index[78:72], pad[79]
//
// one request word at a time; the store read is issued in the accept cycle
// set_left/set_right write the link, then the child (no writes when the free list is empty);
// query reads the parent next; make_tree writes one left link per entry
// reset clears control state only; stores hold no contents until make_tree
// a full output register stalls the final step until the slot frees

module array_binary_tree_free_list (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // position[6:0], node_data[38:7], zero[39]
  input  logic [abtfl_pkg::IN_W-1:0]  s_axis_tdata_i,
  // req_type[2:0]
  input  logic [abtfl_pkg::REQ_W-1:0] s_axis_tuser_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // alloc_index, node_value, left_link, right_link, parent_link,
  // sibling_link, root_index, zero[79]
  output logic [abtfl_pkg::OUT_W-1:0] m_axis_tdata_o,
  // status[0]
  output logic                        m_axis_tuser_o
);
  import abtfl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencing
  abtfl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // stores and result
  abtfl_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o)
  );

endmodule

@@ bench/tb_top.sv @@
// self-checking bench for array_binary_tree_free_list: builds trees, allocates, frees, queries
// depends on abtfl_pkg and the block rtl; predicts every result word and compares field by field
// stimulus runs as named tests in turn, followed by random traffic with random idling on both sides
module tb_top;
  import abtfl_pkg::*;

  localparam int TOTAL_REQUESTS = 1900;
  localparam int TIMEOUT_UNITS  = 40_000_000;

  // one result word as predicted
  typedef struct packed {
    logic              status;
    logic [LINK_W-1:0] alloc;
    logic [DATA_W-1:0] value;
    logic [LINK_W-1:0] left;
    logic [LINK_W-1:0] right;
    logic [LINK_W-1:0] parent;
    logic [LINK_W-1:0] sibling;
    logic [IDX_W-1:0]  root;
  } tree_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata = '0;
  logic [REQ_W-1:0]  s_axis_tuser = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              m_axis_tuser;

  // predicted node store and its written marks
  logic [DATA_W-1:0] node_val    [NODES];
  logic [LINK_W-1:0] node_left   [NODES];
  logic [LINK_W-1:0] node_right  [NODES];
  logic [LINK_W-1:0] node_parent [NODES];
  bit                val_w       [NODES];
  bit                left_w      [NODES];
  bit                right_w     [NODES];
  bit                par_w       [NODES];
  logic [LINK_W-1:0] free_ptr = '0;
  logic [IDX_W-1:0]  root_idx = '0;
  int                live_nodes[$];

  tree_result_t      pending_results[$];
  int                mismatch_count = 0;
  int                requests_done = 0;
  int                tx_gap_max = 14;
  int                rx_gap_max = 14;
  int                rx_hold_cycles = 0;

  array_binary_tree_free_list dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  // clock
  always #10 clk_i = ~clk_i;

  // mark a node as holding a value
  function automatic void mark_value(input logic [IDX_W-1:0] idx);
    if (!val_w[idx]) live_nodes.push_back(int'(idx));
    val_w[idx] = 1'b1;
  endfunction

  // apply one request to the predicted store and return its result word
  function automatic tree_result_t apply_request(input logic [REQ_W-1:0] req,
                                                 input logic [IDX_W-1:0] pos,
                                                 input logic [DATA_W-1:0] data);
    tree_result_t      res;
    logic [IDX_W-1:0]  child;
    logic [LINK_W-1:0] par;
    res = '{status: 1'b0, alloc: LINK_NONE, value: '0, left: LINK_NONE, right: LINK_NONE,
            parent: LINK_NONE, sibling: LINK_NONE, root: '0};
    case (req)
      REQ_MAKE: begin
        for (int i = 0; i < NODES - 1; i++) node_left[i] = LINK_W'(i + 1);
        node_left[NODES-1] = LINK_NONE;
        for (int i = 0; i < NODES; i++) left_w[i] = 1'b1;
        // node 0 is popped as the root
        free_ptr = node_left[0];
        node_parent[0] = LINK_NONE;
        node_right[0] = LINK_NONE;
        node_left[0] = LINK_NONE;
        node_val[0] = data;
        par_w[0] = 1'b1;
        right_w[0] = 1'b1;
        mark_value('0);
        root_idx = '0;
        res.alloc = '0;
      end
      REQ_SETL, REQ_SETR: begin
        if (free_ptr >= NODES) begin
          res.status = 1'b1;
        end else begin
          child = free_ptr[IDX_W-1:0];
          free_ptr = node_left[child];
          // the parent's link to the child is written before the child's own links
          if (req == REQ_SETL) begin
            node_left[pos] = {1'b0, child};
            left_w[pos] = 1'b1;
          end else begin
            node_right[pos] = {1'b0, child};
            right_w[pos] = 1'b1;
          end
          node_parent[child] = {1'b0, pos};
          node_left[child] = LINK_NONE;
          node_right[child] = LINK_NONE;
          node_val[child] = data;
          par_w[child] = 1'b1;
          left_w[child] = 1'b1;
          right_w[child] = 1'b1;
          mark_value(child);
          res.alloc = {1'b0, child};
        end
      end
      REQ_FREE: begin
        node_left[pos] = free_ptr;
        left_w[pos] = 1'b1;
        free_ptr = {1'b0, pos};
      end
      REQ_QUERY: begin
        par = node_parent[pos];
        res.value = node_val[pos];
        res.left = node_left[pos];
        res.right = node_right[pos];
        res.parent = par;
        if (par < NODES)
          res.sibling = (node_left[par[IDX_W-1:0]] == {1'b0, pos}) ?
                        node_right[par[IDX_W-1:0]] : node_left[par[IDX_W-1:0]];
      end
      default: ;
    endcase
    res.root = root_idx;
    return res;
  endfunction

  // a query only touches entries that were written
  function automatic bit query_ok(input logic [IDX_W-1:0] pos);
    logic [LINK_W-1:0] par;
    par = node_parent[pos];
    if (!(val_w[pos] && left_w[pos] && right_w[pos] && par_w[pos])) return 1'b0;
    if (par < NODES) return left_w[par[IDX_W-1:0]] && right_w[par[IDX_W-1:0]];
    return 1'b1;
  endfunction

  // a child allocation reads the link of the free head
  function automatic bit alloc_ok();
    return (free_ptr >= NODES) || left_w[free_ptr[IDX_W-1:0]];
  endfunction

  // mostly nodes in use, sometimes any index
  function automatic logic [IDX_W-1:0] pick_node();
    if (live_nodes.size() > 0 && $urandom_range(0, 3) != 0)
      return IDX_W'(live_nodes[$urandom_range(0, live_nodes.size() - 1)]);
    return IDX_W'($urandom_range(0, NODES - 1));
  endfunction

  // send one request word, predict its result at the accepting edge
  task automatic send_request(input logic [REQ_W-1:0] req, input logic [IDX_W-1:0] pos,
                              input logic [DATA_W-1:0] data);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, data, pos};
    s_axis_tuser  <= req;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(apply_request(req, pos, data));
    if (req <= REQ_QUERY) requests_done++;
  endtask

  task automatic send_query(input logic [IDX_W-1:0] pos);
    send_request(REQ_QUERY, pos, $urandom);
  endtask

  // one field of a result word
  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    tree_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none actual %h/%h",
                 $time, m_axis_tuser, m_axis_tdata);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status",  DATA_W'(want.status),  DATA_W'(m_axis_tuser));
        check_field("alloc",   DATA_W'(want.alloc),   DATA_W'(m_axis_tdata[7:0]));
        check_field("value",   want.value,            m_axis_tdata[39:8]);
        check_field("left",    DATA_W'(want.left),    DATA_W'(m_axis_tdata[47:40]));
        check_field("right",   DATA_W'(want.right),   DATA_W'(m_axis_tdata[55:48]));
        check_field("parent",  DATA_W'(want.parent),  DATA_W'(m_axis_tdata[63:56]));
        check_field("sibling", DATA_W'(want.sibling), DATA_W'(m_axis_tdata[71:64]));
        check_field("root",    DATA_W'(want.root),    DATA_W'(m_axis_tdata[78:72]));
      end
    end
  end

  // result receiver with random stalls and an optional long hold-off
  initial begin
    int n;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_hold_cycles > 0) begin
        n = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        n = $urandom_range(0, rx_gap_max);
      end
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // unknown types and a free before any tree exists
  task automatic test_unknown_types;
    send_request(3'd5, 7'd127, 32'h7fff_ffff);
    send_request(3'd6, 7'd0, 32'h8000_0000);
    send_request(3'd7, 7'h55, $urandom);
    send_request(REQ_FREE, 7'd127, 32'hffff_ffff);
  endtask

  // build, both children, queries of root and children, extreme values
  task automatic test_build_and_links;
    send_request(REQ_MAKE, 7'd0, 32'h8000_0000);
    send_query(7'd0);
    send_request(REQ_SETL, 7'd0, 32'h7fff_ffff);
    send_request(REQ_SETR, 7'd0, 32'hffff_ffff);
    send_query(7'd1);
    send_query(7'd2);
    send_request(REQ_SETL, 7'd127, 32'h0000_0000);
    send_request(REQ_SETR, 7'd127, 32'h0000_0001);
    send_query(7'd4);
  endtask

  // double free makes a cycle in the list, a child that is its own parent
  task automatic test_free_reuse;
    send_request(REQ_FREE, 7'd2, 32'h0);
    send_request(REQ_FREE, 7'd2, 32'h0);
    send_request(REQ_SETL, 7'd1, 32'h1234_5678);
    send_request(REQ_SETR, 7'd1, 32'h9abc_def0);
    send_query(7'd2);
    send_request(REQ_FREE, 7'd9, 32'h0);
    send_request(REQ_SETL, 7'd9, 32'h5a5a_a5a5);
    send_query(7'd9);
  endtask

  // links written into free entries drain the list, then no storage
  task automatic test_empty_list;
    send_request(REQ_MAKE, 7'd3, 32'h0000_0000);
    send_request(REQ_SETL, 7'd2, 32'h1);
    send_request(REQ_SETL, 7'd0, 32'h2);
    send_request(REQ_SETR, 7'd0, 32'h3);
    send_request(REQ_SETL, 7'd0, 32'h4);
    send_request(REQ_FREE, 7'd127, 32'h0);
    send_request(REQ_SETR, 7'd0, 32'h5);
    send_request(REQ_SETR, 7'd5, 32'h6);
  endtask

  // receiver holds off while requests keep coming
  task automatic test_backpressure;
    int saved_gap;
    saved_gap = tx_gap_max;
    tx_gap_max = 0;
    send_request(REQ_MAKE, 7'd0, $urandom);
    rx_hold_cycles = 300;
    for (int i = 0; i < 24; i++) begin
      if (i % 3 == 2) send_query(7'd0);
      else send_request((i % 2) ? REQ_SETR : REQ_SETL, pick_node(), $urandom);
    end
    tx_gap_max = saved_gap;
  endtask

  // one of the unused request codes
  function automatic logic [REQ_W-1:0] REQ_REQ_W_UNKNOWN();
    return REQ_W'($urandom_range(5, 7));
  endfunction

  // random episodes of mostly well-formed tree traffic
  task automatic test_random_traffic(input int target);
    int               ep_len;
    int               kind;
    bit               fill;
    bit               found;
    logic [IDX_W-1:0] pos;
    while (requests_done < target) begin
      case ($urandom_range(0, 2))
        0: tx_gap_max = 0;
        1: tx_gap_max = 3;
        default: tx_gap_max = 14;
      endcase
      case ($urandom_range(0, 2))
        0: rx_gap_max = 0;
        1: rx_gap_max = 3;
        default: rx_gap_max = 14;
      endcase
      fill = ($urandom_range(0, 7) == 0);
      if (fill || $urandom_range(0, 3) == 0)
        send_request(REQ_MAKE, IDX_W'($urandom), $urandom);
      ep_len = fill ? 140 : $urandom_range(20, 60);
      for (int k = 0; k < ep_len; k++) begin
        kind = fill ? $urandom_range(0, 49) : $urandom_range(0, 99);
        pos = pick_node();
        if (kind < 50 && !alloc_ok()) kind = 55;
        if (kind < 25) begin
          send_request(REQ_SETL, pos, $urandom);
        end else if (kind < 50) begin
          send_request(REQ_SETR, pos, $urandom);
        end else if (kind < 64) begin
          send_request(REQ_FREE, pos, $urandom);
        end else if (kind < 94) begin
          found = 1'b0;
          for (int t = 0; t < 8 && !found; t++) begin
            if (query_ok(pos)) found = 1'b1;
            else pos = pick_node();
          end
          if (found) send_query(pos);
          else send_request(REQ_FREE, pos, $urandom);
        end else if (kind < 97) begin
          send_request(REQ_REQ_W_UNKNOWN(), IDX_W'($urandom), $urandom);
        end else begin
          send_request(REQ_MAKE, IDX_W'($urandom), $urandom);
        end
      end
    end
  endtask

  // main sequence
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_unknown_types();
    test_build_and_links();
    test_free_reuse();
    test_empty_list();
    test_backpressure();
    test_random_traffic(TOTAL_REQUESTS);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (NODES + 8) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #TIMEOUT_UNITS;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/abtfl_pkg.sv
rtl/core/abtfl_dpath.sv
rtl/core/abtfl_ctrl.sv
rtl/core/array_binary_tree_free_list.sv
bench/tb_top.sv
